[src/tsd_pkg.sv]
// shared types, constants and the octal field step for the tar stream deframer
package tsd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned SIZE_W  = 36;
    localparam int unsigned CHK_W   = 24;
    localparam int unsigned SUM_W   = 32;
    localparam int unsigned IDX_W   = 9;

    localparam logic [IDX_W-1:0] HDR_LAST   = 9'd511;
    localparam logic [IDX_W-1:0] SIZE_FIRST = 9'd124;
    localparam logic [IDX_W-1:0] SIZE_LAST  = 9'd135;
    localparam logic [IDX_W-1:0] CHK_FIRST  = 9'd148;
    localparam logic [IDX_W-1:0] CHK_LAST   = 9'd155;
    localparam logic [IDX_W-1:0] NAME_LEN   = 9'd100;

    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_SEVEN = 8'h37;
    localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CHAR_BSL   = 8'h5C;
    localparam logic [BYTE_W-1:0] CHAR_FF    = 8'hFF;
    localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;

    // phase codes double as byte roles
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_DATA    = 2'd1;
    localparam logic [1:0] PH_PAD     = 2'd2;
    localparam logic [1:0] PH_DISCARD = 2'd3;

    localparam logic [1:0] KIND_FILE    = 2'd0;
    localparam logic [1:0] KIND_DIR     = 2'd1;
    localparam logic [1:0] KIND_PHANTOM = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    typedef enum logic [1:0] {
        PS_SKIP   = 2'd0,
        PS_SIGNED = 2'd1,
        PS_DIGITS = 2'd2,
        PS_DONE   = 2'd3
    } parse_state_t;

    // name flag bit positions
    localparam int unsigned NF_NUL        = 0;
    localparam int unsigned NF_EMPTY      = 1;
    localparam int unsigned NF_FIRST_FF   = 2;
    localparam int unsigned NF_SECOND_NUL = 3;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_out;
        logic [1:0]        byte_role;
        logic              header_done;
        logic [1:0]        entry_kind;
        logic [SIZE_W-1:0] file_size;
        logic              checksum_ok;
        logic              data_last;
    } result_t;

    typedef struct packed {
        parse_state_t      st;
        logic [SIZE_W-1:0] acc;
    } octal_t;

    // one byte of an octal scan; acc is truncated by the caller for narrower fields
    function automatic octal_t octal_step(input octal_t cur, input logic [BYTE_W-1:0] b);
        octal_t nxt;
        logic   digit;
        logic   space;
        nxt   = cur;
        digit = (b >= CHAR_ZERO) && (b <= CHAR_SEVEN);
        space = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
        unique case (cur.st)
            PS_SKIP: begin
                if (space) begin
                    nxt.st = PS_SKIP;
                end else if (b == CHAR_PLUS) begin
                    nxt.st = PS_SIGNED;
                end else if (b == CHAR_MINUS) begin
                    nxt.acc = '0;
                    nxt.st  = PS_DONE;
                end else if (digit) begin
                    nxt.acc = {{(SIZE_W-3){1'b0}}, b[2:0]};
                    nxt.st  = PS_DIGITS;
                end else begin
                    nxt.st = PS_DONE;
                end
            end
            PS_SIGNED, PS_DIGITS: begin
                if (digit) begin
                    nxt.acc = {cur.acc[SIZE_W-4:0], b[2:0]};
                    nxt.st  = PS_DIGITS;
                end else begin
                    nxt.st = PS_DONE;
                end
            end
            default: nxt = cur;
        endcase
        return nxt;
    endfunction

endpackage

[src/tsd_in_reg.sv]
// input register stage holding one request byte
module tsd_in_reg
    import tsd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_byte_in,
    input  logic              load,
    output logic              in_valid,
    output logic [BYTE_W-1:0] in_byte
);

    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;

    assign s_ready  = !valid_reg || load;
    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (load) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_byte_in;
        end
    end

endmodule

[src/tsd_deframe.sv]
// header parsing, checksum, entry classification and data/padding counters
module tsd_deframe
    import tsd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  logic [BYTE_W-1:0] in_byte,
    output result_t           res
);

    logic [1:0]        phase_reg,     phase_next;
    logic [IDX_W-1:0]  hdr_idx_reg,   hdr_idx_next;
    logic [SUM_W-1:0]  sum_reg,       sum_next;
    octal_t            size_reg,      size_next;
    parse_state_t      chk_st_reg,    chk_st_next;
    logic [CHK_W-1:0]  chk_acc_reg,   chk_acc_next;
    logic [3:0]        flags_reg,     flags_next;
    logic [BYTE_W-1:0] last_reg,      last_next;
    logic [SIZE_W-1:0] data_rem_reg,  data_rem_next;
    logic [IDX_W-1:0]  pad_rem_reg,   pad_rem_next;

    logic [BYTE_W-1:0] cb;
    logic              in_size;
    logic              in_chk;
    octal_t            chk_cur;
    octal_t            chk_stepped;
    logic [SIZE_W-1:0] data_dec;

    assign in_size = (hdr_idx_reg >= SIZE_FIRST) && (hdr_idx_reg <= SIZE_LAST);
    assign in_chk  = (hdr_idx_reg >= CHK_FIRST) && (hdr_idx_reg <= CHK_LAST);
    assign cb      = in_chk ? CHAR_SPACE : in_byte;
    assign chk_cur = '{st: chk_st_reg, acc: {{(SIZE_W-CHK_W){1'b0}}, chk_acc_reg}};
    assign chk_stepped = octal_step(chk_cur, in_byte);
    assign data_dec = data_rem_reg - {{(SIZE_W-1){1'b0}}, 1'b1};

    always_comb begin
        phase_next    = phase_reg;
        hdr_idx_next  = hdr_idx_reg;
        sum_next      = sum_reg;
        size_next     = size_reg;
        chk_st_next   = chk_st_reg;
        chk_acc_next  = chk_acc_reg;
        flags_next    = flags_reg;
        last_next     = last_reg;
        data_rem_next = data_rem_reg;
        pad_rem_next  = pad_rem_reg;

        res             = '0;
        res.byte_out    = in_byte;
        res.byte_role   = phase_reg;

        unique case (phase_reg)
            PH_HEADER: begin
                sum_next = sum_reg + {{(SUM_W-BYTE_W){cb[BYTE_W-1]}}, cb};
                if (hdr_idx_reg < NAME_LEN) begin
                    if ((hdr_idx_reg == '0) && (in_byte == CHAR_FF)) begin
                        flags_next[NF_FIRST_FF] = 1'b1;
                    end
                    if (!flags_reg[NF_NUL]) begin
                        if (in_byte == CHAR_NUL) begin
                            flags_next[NF_NUL] = 1'b1;
                            if (hdr_idx_reg == 9'd0) begin
                                flags_next[NF_EMPTY] = 1'b1;
                            end
                            if (hdr_idx_reg == 9'd1) begin
                                flags_next[NF_SECOND_NUL] = 1'b1;
                            end
                        end else begin
                            last_next = in_byte;
                        end
                    end
                end
                if (in_size) begin
                    size_next = octal_step(size_reg, in_byte);
                end
                if (in_chk) begin
                    chk_st_next  = chk_stepped.st;
                    chk_acc_next = chk_stepped.acc[CHK_W-1:0];
                end

                if (hdr_idx_reg == HDR_LAST) begin
                    res.header_done = 1'b1;
                    res.file_size   = size_reg.acc;
                    res.checksum_ok = (sum_next == {{(SUM_W-CHK_W){1'b0}}, chk_acc_reg});
                    if (flags_reg[NF_FIRST_FF] && flags_reg[NF_SECOND_NUL]) begin
                        res.entry_kind = KIND_PHANTOM;
                    end else if (flags_reg[NF_EMPTY]) begin
                        res.entry_kind = KIND_END;
                        phase_next     = PH_DISCARD;
                    end else if ((last_reg == CHAR_SLASH) || (last_reg == CHAR_BSL)) begin
                        res.entry_kind = KIND_DIR;
                    end else begin
                        res.entry_kind = KIND_FILE;
                        if (size_reg.acc != '0) begin
                            data_rem_next = size_reg.acc;
                            pad_rem_next  = '0 - size_reg.acc[IDX_W-1:0];
                            phase_next    = PH_DATA;
                        end
                    end
                    hdr_idx_next = '0;
                    sum_next     = '0;
                    size_next    = '{st: PS_SKIP, acc: '0};
                    chk_st_next  = PS_SKIP;
                    chk_acc_next = '0;
                    flags_next   = '0;
                    last_next    = '0;
                end else begin
                    hdr_idx_next = hdr_idx_reg + 9'd1;
                end
            end
            PH_DATA: begin
                data_rem_next = data_dec;
                if (data_dec == '0) begin
                    res.data_last = 1'b1;
                    phase_next    = (pad_rem_reg != '0) ? PH_PAD : PH_HEADER;
                end
            end
            PH_PAD: begin
                pad_rem_next = pad_rem_reg - 9'd1;
                if (pad_rem_next == '0) begin
                    phase_next = PH_HEADER;
                end
            end
            PH_DISCARD: begin
                phase_next = PH_DISCARD;
            end
            default: phase_next = phase_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HEADER;
            hdr_idx_reg  <= '0;
            sum_reg      <= '0;
            size_reg     <= '{st: PS_SKIP, acc: '0};
            chk_st_reg   <= PS_SKIP;
            chk_acc_reg  <= '0;
            flags_reg    <= '0;
            last_reg     <= '0;
            data_rem_reg <= '0;
            pad_rem_reg  <= '0;
        end else if (load) begin
            phase_reg    <= phase_next;
            hdr_idx_reg  <= hdr_idx_next;
            sum_reg      <= sum_next;
            size_reg     <= size_next;
            chk_st_reg   <= chk_st_next;
            chk_acc_reg  <= chk_acc_next;
            flags_reg    <= flags_next;
            last_reg     <= last_next;
            data_rem_reg <= data_rem_next;
            pad_rem_reg  <= pad_rem_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_end_to_discard: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && res.header_done && (res.entry_kind == KIND_END)) |=> (phase_reg == PH_DISCARD))
        else $error("end of archive did not enter discard");

    a_discard_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DISCARD) |=> (phase_reg == PH_DISCARD))
        else $error("left discard phase");

    a_last_leaves_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && res.data_last) |=> (phase_reg != PH_DATA))
        else $error("still in data after last data byte");

    a_idx_clear_outside_hdr: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_HEADER) |-> ((hdr_idx_reg == '0) && (sum_reg == '0)))
        else $error("header state not cleared outside header phase");
`endif

endmodule

[src/tsd_out_reg.sv]
// result register stage
module tsd_out_reg
    import tsd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  result_t res,
    output logic    load,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_res
);

    logic    valid_reg;
    result_t res_reg;

    assign load    = in_valid && (!valid_reg || m_ready);
    assign m_valid = valid_reg;
    assign m_res   = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res;
        end
    end

endmodule

[src/tar_stream_deframer_top.sv]
// Tar stream deframer top level. One archive byte is taken per cycle unless the output
// stalls, and one tagged result byte comes out per input byte; each result passes the
// input register and then the result register before it shows on the m_ ports. Throughput
// is one byte per cycle when the output is not stalled, set by the single state update
// between the input register and the result register. Header parsing, checksum and
// the data and padding counters all advance once per byte, and header_done,
// entry_kind, file_size and checksum_ok are reported on header byte 511.
module tar_stream_deframer_top
    import tsd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [BYTE_W-1:0] s_byte_in,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_byte_out,
    output logic [1:0]        m_byte_role,
    output logic              m_header_done,
    output logic [1:0]        m_entry_kind,
    output logic [SIZE_W-1:0] m_file_size,
    output logic              m_checksum_ok,
    output logic              m_data_last
);

    logic              load;
    logic              in_valid;
    logic [BYTE_W-1:0] in_byte;
    result_t           res;
    result_t           m_res;

    tsd_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_byte_in (s_byte_in),
        .load      (load),
        .in_valid  (in_valid),
        .in_byte   (in_byte)
    );

    tsd_deframe u_deframe (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (load),
        .in_byte (in_byte),
        .res     (res)
    );

    tsd_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid),
        .res      (res),
        .load     (load),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_res    (m_res)
    );

    assign m_byte_out    = m_res.byte_out;
    assign m_byte_role   = m_res.byte_role;
    assign m_header_done = m_res.header_done;
    assign m_entry_kind  = m_res.entry_kind;
    assign m_file_size   = m_res.file_size;
    assign m_checksum_ok = m_res.checksum_ok;
    assign m_data_last   = m_res.data_last;

endmodule

[tb/tar_stream_deframer_top_test.sv]
// self-checking testbench for the tar stream deframer: directed and random archives
`timescale 1ns / 100ps

module tar_stream_deframer_top_test
    import tsd_pkg::*;
();

    localparam int CYCLE_LIMIT = 1_000_000;

    class byte_tag_scoreboard;
        result_t           tags_due[$];
        int                mismatches;
        logic [1:0]        phase;
        logic [IDX_W-1:0]  hdr_idx;
        logic [SUM_W-1:0]  hdr_sum;
        octal_t            size_scan;
        octal_t            chk_scan;
        logic [3:0]        name_flags;
        logic [BYTE_W-1:0] name_last;
        logic [SIZE_W-1:0] data_left;
        logic [IDX_W-1:0]  pad_left;

        function new();
            mismatches = 0;
            phase      = PH_HEADER;
            data_left  = '0;
            pad_left   = '0;
            clear_header();
        endfunction

        function void clear_header();
            hdr_idx       = '0;
            hdr_sum       = '0;
            size_scan.st  = PS_SKIP;
            size_scan.acc = '0;
            chk_scan.st   = PS_SKIP;
            chk_scan.acc  = '0;
            name_flags    = '0;
            name_last     = '0;
        endfunction

        function octal_t scan_octal(octal_t cur, logic [BYTE_W-1:0] b, int width);
            octal_t            nxt;
            logic              digit;
            logic              blank;
            logic [SIZE_W-1:0] keep;
            nxt   = cur;
            digit = (b >= CHAR_ZERO) && (b <= CHAR_SEVEN);
            blank = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
            keep  = (width >= SIZE_W) ? '1 : ((36'd1 << width) - 36'd1);
            case (cur.st)
                PS_SKIP: begin
                    if (!blank) begin
                        if (b == CHAR_PLUS) begin
                            nxt.st = PS_SIGNED;
                        end else if (b == CHAR_MINUS) begin
                            nxt.acc = '0;
                            nxt.st  = PS_DONE;
                        end else if (digit) begin
                            nxt.acc = SIZE_W'(b - CHAR_ZERO);
                            nxt.st  = PS_DIGITS;
                        end else begin
                            nxt.st = PS_DONE;
                        end
                    end
                end
                PS_SIGNED, PS_DIGITS: begin
                    if (digit) begin
                        nxt.acc = ((cur.acc << 3) | SIZE_W'(b - CHAR_ZERO)) & keep;
                        nxt.st  = PS_DIGITS;
                    end else begin
                        nxt.st = PS_DONE;
                    end
                end
                default: ;
            endcase
            return nxt;
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b);
            result_t           due;
            logic [BYTE_W-1:0] cb;
            due           = '0;
            due.byte_out  = b;
            due.byte_role = phase;
            case (phase)
                PH_HEADER: begin
                    cb = (hdr_idx >= CHK_FIRST && hdr_idx <= CHK_LAST) ? CHAR_SPACE : b;
                    hdr_sum = hdr_sum + {{(SUM_W-BYTE_W){cb[BYTE_W-1]}}, cb};
                    if (hdr_idx < NAME_LEN) begin
                        if (hdr_idx == 0 && b == CHAR_FF) name_flags[NF_FIRST_FF] = 1'b1;
                        if (!name_flags[NF_NUL]) begin
                            if (b == CHAR_NUL) begin
                                name_flags[NF_NUL] = 1'b1;
                                if (hdr_idx == 0) name_flags[NF_EMPTY] = 1'b1;
                                if (hdr_idx == 1) name_flags[NF_SECOND_NUL] = 1'b1;
                            end else begin
                                name_last = b;
                            end
                        end
                    end
                    if (hdr_idx >= SIZE_FIRST && hdr_idx <= SIZE_LAST)
                        size_scan = scan_octal(size_scan, b, SIZE_W);
                    if (hdr_idx >= CHK_FIRST && hdr_idx <= CHK_LAST)
                        chk_scan = scan_octal(chk_scan, b, CHK_W);
                    if (hdr_idx == HDR_LAST) begin
                        due.header_done = 1'b1;
                        due.file_size   = size_scan.acc;
                        due.checksum_ok =
                            (hdr_sum == {{(SUM_W-CHK_W){1'b0}}, chk_scan.acc[CHK_W-1:0]});
                        if (name_flags[NF_FIRST_FF] && name_flags[NF_SECOND_NUL]) begin
                            due.entry_kind = KIND_PHANTOM;
                        end else if (name_flags[NF_EMPTY]) begin
                            due.entry_kind = KIND_END;
                            phase          = PH_DISCARD;
                        end else if (name_last == CHAR_SLASH || name_last == CHAR_BSL) begin
                            due.entry_kind = KIND_DIR;
                        end else begin
                            due.entry_kind = KIND_FILE;
                            if (size_scan.acc != 0) begin
                                data_left = size_scan.acc;
                                pad_left  = 9'd0 - size_scan.acc[IDX_W-1:0];
                                phase     = PH_DATA;
                            end
                        end
                        clear_header();
                    end else begin
                        hdr_idx++;
                    end
                end
                PH_DATA: begin
                    data_left--;
                    if (data_left == 0) begin
                        due.data_last = 1'b1;
                        phase = (pad_left != 0) ? PH_PAD : PH_HEADER;
                    end
                end
                PH_PAD: begin
                    pad_left--;
                    if (pad_left == 0) phase = PH_HEADER;
                end
                default: ;
            endcase
            tags_due.push_back(due);
        endfunction

        function void compare_field(string field, logic [SIZE_W-1:0] want,
                                    logic [SIZE_W-1:0] seen);
            if (want !== seen) begin
                mismatches++;
                $display("%0t: %s expected %0h got %0h", $time, field, want, seen);
            end
        endfunction

        function void check_tagged(result_t seen);
            result_t want;
            if (tags_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none got byte %0h",
                         $time, seen.byte_out);
                return;
            end
            want = tags_due.pop_front();
            compare_field("byte_out", want.byte_out, seen.byte_out);
            compare_field("byte_role", want.byte_role, seen.byte_role);
            compare_field("header_done", want.header_done, seen.header_done);
            compare_field("entry_kind", want.entry_kind, seen.entry_kind);
            compare_field("file_size", want.file_size, seen.file_size);
            compare_field("checksum_ok", want.checksum_ok, seen.checksum_ok);
            compare_field("data_last", want.data_last, seen.data_last);
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [BYTE_W-1:0] s_byte_in;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [BYTE_W-1:0] m_byte_out;
    logic [1:0]        m_byte_role;
    logic              m_header_done;
    logic [1:0]        m_entry_kind;
    logic [SIZE_W-1:0] m_file_size;
    logic              m_checksum_ok;
    logic              m_data_last;

    byte_tag_scoreboard board;
    logic [BYTE_W-1:0]  hdr [512];
    int                 send_idle_pct  = 0;
    int                 recv_stall_pct = 0;
    int                 cycle_count    = 0;

    tar_stream_deframer_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_byte_in     (s_byte_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_byte_out    (m_byte_out),
        .m_byte_role   (m_byte_role),
        .m_header_done (m_header_done),
        .m_entry_kind  (m_entry_kind),
        .m_file_size   (m_file_size),
        .m_checksum_ok (m_checksum_ok),
        .m_data_last   (m_data_last)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_tagged({m_byte_out, m_byte_role, m_header_done, m_entry_kind,
                                m_file_size, m_checksum_ok, m_data_last});
    end

    // called and returns at a falling edge
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_byte_in <= b;
        do @(posedge aclk); while (!s_ready);
        board.note_byte(b);
        @(negedge aclk);
    endtask

    function automatic void put_text(int at, string s);
        for (int i = 0; i < s.len(); i++) hdr[at + i] = s[i];
    endfunction

    function automatic void start_header();
        for (int i = 0; i < 512; i++) hdr[i] = CHAR_NUL;
        put_text(100, "0000644");
        put_text(108, "0001750");
        put_text(116, "0001750");
        put_text(136, "14000000000");
        put_text(156, "0");
        put_text(257, "ustar");
        put_text(263, "00");
    endfunction

    function automatic void put_octal(int at, int digits, logic [SIZE_W-1:0] v);
        for (int i = 0; i < digits; i++)
            hdr[at + digits - 1 - i] = CHAR_ZERO + {5'd0, v[3*i +: 3]};
    endfunction

    function automatic void put_name(int len, bit as_dir);
        for (int i = 0; i < len; i++) hdr[i] = 8'($urandom_range(33, 126));
        if (as_dir)
            hdr[len - 1] = $urandom_range(1) ? CHAR_SLASH : CHAR_BSL;
        else if (hdr[len - 1] == CHAR_SLASH || hdr[len - 1] == CHAR_BSL)
            hdr[len - 1] = "a";
    endfunction

    // mix of blanks, signs, digits and junk; at most four digits
    function automatic void odd_field(int at, int len);
        for (int i = 0; i < len; i++) begin
            if (i >= 4) begin
                hdr[at + i] = CHAR_NUL;
            end else begin
                case ($urandom_range(9))
                    0:       hdr[at + i] = CHAR_SPACE;
                    1:       hdr[at + i] = 8'($urandom_range(CHAR_TAB, CHAR_CR));
                    2:       hdr[at + i] = CHAR_PLUS;
                    3:       hdr[at + i] = CHAR_MINUS;
                    8:       hdr[at + i] = 8'($urandom_range(255));
                    9:       hdr[at + i] = CHAR_NUL;
                    default: hdr[at + i] = 8'($urandom_range(CHAR_ZERO, CHAR_SEVEN));
                endcase
            end
        end
    endfunction

    function automatic void seal_checksum(bit full_width);
        int total;
        for (int i = 148; i < 156; i++) hdr[i] = CHAR_SPACE;
        total = 0;
        for (int i = 0; i < 512; i++) total += int'($signed(hdr[i]));
        if (full_width) begin
            put_octal(148, 8, 36'(total));
        end else begin
            put_octal(148, 6, 36'(total));
            hdr[154] = CHAR_NUL;
            hdr[155] = CHAR_SPACE;
        end
    endfunction

    // header, then whatever data and padding the header calls for
    task automatic send_entry();
        for (int i = 0; i < 512; i++) send_byte(hdr[i]);
        while (board.phase == PH_DATA || board.phase == PH_PAD)
            send_byte(board.phase == PH_DATA ? 8'($urandom) : CHAR_NUL);
    endtask

    task automatic plain_file(string nm, int fsize);
        start_header();
        put_text(0, nm);
        put_octal(124, 11, 36'(fsize));
        seal_checksum(1'b0);
        send_entry();
    endtask

    task automatic random_entry();
        int pick;
        int fsize;
        pick = $urandom_range(99);
        start_header();
        put_name($urandom_range(1, 100), pick >= 55 && pick < 70);
        if (pick < 55) begin
            fsize = ($urandom_range(9) == 0) ? $urandom_range(700, 2100) : $urandom_range(700);
            put_octal(124, 11, 36'(fsize));
            seal_checksum($urandom_range(3) == 0);
        end else if (pick < 78) begin
            if (pick >= 70) begin
                hdr[0] = CHAR_FF;
                hdr[1] = CHAR_NUL;
            end
            put_octal(124, 11 + $urandom_range(1), 36'({$urandom, $urandom}));
            seal_checksum(1'($urandom_range(1)));
        end else if (pick < 88) begin
            odd_field(124, 12);
            seal_checksum(1'b0);
            if ($urandom_range(1))
                odd_field(148, 8);
            else
                hdr[148 + $urandom_range(7)] = 8'($urandom_range(255));
        end else begin
            for (int i = 0; i < 512; i++) hdr[i] = 8'($urandom_range(255));
            hdr[0] = 8'($urandom_range(1, 255));
            odd_field(124, 12);
        end
        send_entry();
    endtask

    initial begin
        board     = new();
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_byte_in = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        plain_file("empty.txt", 0);
        plain_file("one.bin", 1);
        plain_file("block.bin", 512);
        plain_file("over.bin", 513);
        plain_file("noterm18", 0);

        // directory with the widest size field
        start_header();
        put_text(0, "deep/dir/");
        put_text(124, "777777777777");
        seal_checksum(1'b0);
        send_entry();

        start_header();
        put_text(0, "win");
        hdr[3] = CHAR_BSL;
        seal_checksum(1'b0);
        send_entry();

        // unterminated name ending in a slash
        start_header();
        for (int i = 0; i < 99; i++) hdr[i] = "n";
        hdr[99] = CHAR_SLASH;
        put_octal(124, 11, 7);
        seal_checksum(1'b1);
        send_entry();

        // phantom entry
        start_header();
        hdr[0] = CHAR_FF;
        put_octal(124, 11, 100);
        seal_checksum(1'b0);
        send_entry();

        // leading ff not followed by nul is a plain file
        start_header();
        hdr[0] = CHAR_FF;
        hdr[1] = "x";
        put_octal(124, 11, 3);
        seal_checksum(1'b0);
        send_entry();

        // blanks then plus sign
        start_header();
        put_text(0, "blank.txt");
        for (int i = 0; i < 5; i++) hdr[124 + i] = CHAR_TAB + 8'(i);
        hdr[129] = CHAR_SPACE;
        put_text(130, "+17");
        seal_checksum(1'b0);
        send_entry();

        start_header();
        put_text(0, "minus.txt");
        put_text(124, "-17");
        seal_checksum(1'b0);
        send_entry();

        start_header();
        put_text(0, "plus.txt");
        put_text(124, "+");
        seal_checksum(1'b0);
        send_entry();

        start_header();
        put_text(0, "eight.txt");
        put_text(124, "18");
        seal_checksum(1'b0);
        send_entry();

        start_header();
        put_text(0, "junk.txt");
        put_text(124, "x5");
        seal_checksum(1'b0);
        send_entry();

        // corrupted checksum digit
        start_header();
        put_text(0, "badsum.txt");
        put_octal(124, 11, 2);
        seal_checksum(1'b0);
        hdr[153] = hdr[153] ^ 8'h01;
        send_entry();

        // negative running sum
        start_header();
        put_text(0, "neg.txt");
        for (int i = 345; i < 500; i++) hdr[i] = 8'h80;
        put_octal(124, 11, 5);
        seal_checksum(1'b0);
        send_entry();

        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            repeat (12) random_entry();
        end

        // end of archive, then bytes that must be discarded
        start_header();
        seal_checksum(1'b0);
        send_entry();
        repeat (300) send_byte(8'($urandom));
        s_valid <= 1'b0;

        while (board.tags_due.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (board.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
